// ===== sv/mrd_pkg.sv =====
package mrd_pkg;

    typedef enum logic [2:0] {
        PH_ADDR,
        PH_FUNC,
        PH_LEN,
        PH_DATA,
        PH_CRCLO,
        PH_CRCHI,
        PH_BADADDR
    } phase_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_CRC,
        SEQ_DECIDE,
        SEQ_RD,
        SEQ_WORD,
        SEQ_STAT
    } seq_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_STATUS,
        RES_BURST
    } res_t;

    typedef struct packed {
        logic load;
        logic preset;
    } crc_cmd_t;

    typedef struct packed {
        logic busy;
        logic zero;
    } crc_stat_t;

    localparam logic [15:0] CRC_PRESET = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    localparam logic [7:0] FUNC_READ = 8'h03;
    localparam logic [7:0] FUNC_EXC  = 8'h83;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_CRC   = 3'd1;
    localparam logic [2:0] ST_EXCEPTION = 3'd2;
    localparam logic [2:0] ST_BAD_ADDR  = 3'd3;
    localparam logic [2:0] ST_BAD_FUNC  = 3'd4;
    localparam logic [2:0] ST_TRUNCATED = 3'd5;
    localparam logic [2:0] ST_OVERSIZE  = 3'd6;

    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] CFG_DEVICE_ADDRESS    = 2'd0;
    localparam logic [1:0] CFG_FRAMES_EXPECTED   = 2'd1;
    localparam logic [1:0] CFG_SIGNED_FRAME_MASK = 2'd2;

    localparam logic [7:0] DEVICE_ADDRESS_RESET    = 8'h01;
    localparam logic [3:0] FRAMES_EXPECTED_RESET   = 4'd3;
    localparam logic [7:0] SIGNED_FRAME_MASK_RESET = 8'h03;

endpackage

// ===== sv/mrd_crc_serial.sv =====
module mrd_crc_serial
    import mrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  crc_cmd_t   cmd,
    input  logic [7:0] data,
    output crc_stat_t  stat
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;

    always_comb
    begin
        crc_next = crc_reg;
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            crc_next = (cmd.preset ? CRC_PRESET : crc_reg) ^ {8'h00, data};
            cnt_next = 4'd8;
        end
        else if (cnt_reg != 4'd0)
        begin
            crc_next = crc_reg[0] ? ((crc_reg >> 1) ^ CRC_POLY) : (crc_reg >> 1);
            cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_PRESET;
            cnt_reg <= 4'd0;
        end
        else
        begin
            crc_reg <= crc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign stat.busy = (cnt_reg != 4'd0);
    assign stat.zero = (crc_reg == 16'h0000);

endmodule

// ===== sv/mrd_word_mem.sv =====
module mrd_word_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/mrd_parser.sv =====
module mrd_parser
    import mrd_pkg::*;
#(
    parameter int MAX_WORDS = 32,
    parameter int AW        = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    data_byte,
    input  logic          end_of_sample,
    input  logic [7:0]    device_address,
    input  logic [3:0]    frames_eff,
    input  logic [7:0]    signed_frame_mask,
    output crc_cmd_t      crc_cmd,
    output logic [7:0]    crc_data,
    input  crc_stat_t     crc_stat,
    output logic          mem_wr_en,
    output logic [AW-1:0] mem_wr_addr,
    output logic [15:0]   mem_wr_data,
    output logic          mem_rd_en,
    output logic [AW-1:0] mem_rd_addr,
    input  logic [15:0]   mem_rd_data,
    output logic          out_valid,
    input  logic          out_stall,
    output logic          kind,
    output logic [2:0]    frame_index,
    output logic [4:0]    word_index,
    output logic [15:0]   word_value,
    output logic          is_signed,
    output logic [2:0]    status,
    output logic          last
);

    seq_t        state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [2:0]  frame_reg, frame_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  bcnt_reg, bcnt_next;
    logic [7:0]  held_reg, held_next;
    logic        stopped_reg, stopped_next;
    logic [7:0]  hi_reg, hi_next;
    logic [7:0]  byte_reg, byte_next;
    logic        eos_reg, eos_next;
    logic [2:0]  emit_frame_reg, emit_frame_next;
    logic        emit_sign_reg, emit_sign_next;
    logic [6:0]  emit_total_reg, emit_total_next;
    logic [6:0]  emit_cnt_reg, emit_cnt_next;
    logic [2:0]  emit_status_reg, emit_status_next;

    logic        out_valid_reg, out_valid_next;
    logic        kind_reg, kind_next;
    logic [2:0]  frame_index_reg, frame_index_next;
    logic [4:0]  word_index_reg, word_index_next;
    logic [15:0] word_value_reg, word_value_next;
    logic        is_signed_reg, is_signed_next;
    logic [2:0]  status_reg, status_next;
    logic        last_reg, last_next;

    res_t        res_kind;
    logic        out_free;
    logic [7:0]  bcnt_inc;

    assign out_free = !out_valid_reg || !out_stall;
    assign bcnt_inc = bcnt_reg + 8'd1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = SEQ_CRC;
                end
            end
            SEQ_CRC:
            begin
                if (!crc_stat.busy)
                begin
                    state_next = SEQ_DECIDE;
                end
            end
            SEQ_DECIDE:
            begin
                case (res_kind)
                    RES_STATUS: state_next = SEQ_STAT;
                    RES_BURST:  state_next = (len_reg[7:1] == 7'd0) ? SEQ_STAT : SEQ_RD;
                    default:    state_next = SEQ_IDLE;
                endcase
            end
            SEQ_RD:
            begin
                state_next = SEQ_WORD;
            end
            SEQ_WORD:
            begin
                if (out_free)
                begin
                    state_next = (emit_cnt_reg + 7'd1 == emit_total_reg) ? SEQ_STAT : SEQ_RD;
                end
            end
            SEQ_STAT:
            begin
                if (out_free)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        phase_next       = phase_reg;
        frame_next       = frame_reg;
        len_next         = len_reg;
        bcnt_next        = bcnt_reg;
        held_next        = held_reg;
        stopped_next     = stopped_reg;
        hi_next          = hi_reg;
        byte_next        = byte_reg;
        eos_next         = eos_reg;
        emit_frame_next  = emit_frame_reg;
        emit_sign_next   = emit_sign_reg;
        emit_total_next  = emit_total_reg;
        emit_cnt_next    = emit_cnt_reg;
        emit_status_next = emit_status_reg;

        out_valid_next   = out_valid_reg && out_stall;
        kind_next        = kind_reg;
        frame_index_next = frame_index_reg;
        word_index_next  = word_index_reg;
        word_value_next  = word_value_reg;
        is_signed_next   = is_signed_reg;
        status_next      = status_reg;
        last_next        = last_reg;

        res_kind       = RES_NONE;
        in_stall       = 1'b1;
        crc_cmd.load   = 1'b0;
        crc_cmd.preset = 1'b0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = bcnt_reg[AW:1];
        mem_wr_data    = {hi_reg, byte_reg};
        mem_rd_en      = 1'b0;

        case (state_reg)
            SEQ_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    byte_next      = data_byte;
                    eos_next       = end_of_sample;
                    crc_cmd.load   = 1'b1;
                    crc_cmd.preset = (phase_reg == PH_ADDR);
                end
            end
            SEQ_DECIDE:
            begin
                emit_frame_next = frame_reg;
                emit_sign_next  = signed_frame_mask[frame_reg];
                emit_total_next = len_reg[7:1];
                emit_cnt_next   = 7'd0;
                if (!stopped_reg && frames_eff != 4'd0)
                begin
                    case (phase_reg)
                        PH_ADDR:
                        begin
                            bcnt_next  = 8'd0;
                            phase_next = (byte_reg != device_address) ? PH_BADADDR : PH_FUNC;
                        end
                        PH_BADADDR:
                        begin
                            bcnt_next = bcnt_inc;
                            if (bcnt_inc >= 8'd2)
                            begin
                                res_kind         = RES_STATUS;
                                emit_status_next = ST_BAD_ADDR;
                                stopped_next     = 1'b1;
                            end
                        end
                        PH_FUNC:
                        begin
                            held_next  = byte_reg;
                            phase_next = PH_LEN;
                        end
                        PH_LEN:
                        begin
                            len_next  = byte_reg;
                            bcnt_next = 8'd0;
                            if (held_reg == FUNC_READ)
                            begin
                                if (byte_reg[7:1] > 7'(MAX_WORDS))
                                begin
                                    res_kind         = RES_STATUS;
                                    emit_status_next = ST_OVERSIZE;
                                    stopped_next     = 1'b1;
                                end
                                else
                                begin
                                    phase_next = (byte_reg != 8'd0) ? PH_DATA : PH_CRCLO;
                                end
                            end
                            else if (held_reg == FUNC_EXC)
                            begin
                                res_kind         = RES_STATUS;
                                emit_status_next = ST_EXCEPTION;
                                if ({1'b0, frame_reg} + 4'd1 >= frames_eff)
                                begin
                                    stopped_next = 1'b1;
                                end
                                else
                                begin
                                    frame_next = frame_reg + 3'd1;
                                end
                                phase_next = (byte_reg != 8'd0) ? PH_DATA : PH_CRCLO;
                            end
                            else
                            begin
                                res_kind         = RES_STATUS;
                                emit_status_next = ST_BAD_FUNC;
                                stopped_next     = 1'b1;
                            end
                        end
                        PH_DATA:
                        begin
                            if (held_reg == FUNC_READ)
                            begin
                                if (!bcnt_reg[0])
                                begin
                                    hi_next = byte_reg;
                                end
                                else if (bcnt_reg[7:1] < 7'(MAX_WORDS))
                                begin
                                    mem_wr_en = 1'b1;
                                end
                            end
                            bcnt_next = bcnt_inc;
                            if (bcnt_inc >= len_reg)
                            begin
                                phase_next = PH_CRCLO;
                            end
                        end
                        PH_CRCLO:
                        begin
                            phase_next = PH_CRCHI;
                        end
                        PH_CRCHI:
                        begin
                            if (held_reg == FUNC_READ)
                            begin
                                if (crc_stat.zero)
                                begin
                                    res_kind         = RES_BURST;
                                    emit_status_next = ST_OK;
                                end
                                else
                                begin
                                    res_kind         = RES_STATUS;
                                    emit_status_next = ST_BAD_CRC;
                                end
                                if ({1'b0, frame_reg} + 4'd1 >= frames_eff)
                                begin
                                    stopped_next = 1'b1;
                                end
                                else
                                begin
                                    frame_next = frame_reg + 3'd1;
                                end
                            end
                            phase_next = PH_ADDR;
                        end
                        default:
                        begin
                            phase_next = PH_ADDR;
                        end
                    endcase
                end
                if (eos_reg)
                begin
                    if (!stopped_next && held_next == FUNC_READ &&
                        (phase_next inside {PH_DATA, PH_CRCLO, PH_CRCHI}))
                    begin
                        res_kind         = RES_STATUS;
                        emit_status_next = ST_TRUNCATED;
                    end
                    phase_next   = PH_ADDR;
                    frame_next   = 3'd0;
                    len_next     = 8'd0;
                    bcnt_next    = 8'd0;
                    held_next    = 8'd0;
                    stopped_next = 1'b0;
                end
            end
            SEQ_RD:
            begin
                mem_rd_en = 1'b1;
            end
            SEQ_WORD:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    kind_next        = KIND_WORD;
                    frame_index_next = emit_frame_reg;
                    word_index_next  = 5'(emit_cnt_reg);
                    word_value_next  = mem_rd_data;
                    is_signed_next   = emit_sign_reg;
                    status_next      = ST_OK;
                    last_next        = 1'b0;
                    emit_cnt_next    = emit_cnt_reg + 7'd1;
                end
            end
            SEQ_STAT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    kind_next        = KIND_STATUS;
                    frame_index_next = emit_frame_reg;
                    word_index_next  = 5'd0;
                    word_value_next  = 16'h0000;
                    is_signed_next   = 1'b0;
                    status_next      = emit_status_reg;
                    last_next        = 1'b1;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            phase_reg     <= PH_ADDR;
            frame_reg     <= 3'd0;
            len_reg       <= 8'd0;
            bcnt_reg      <= 8'd0;
            held_reg      <= 8'd0;
            stopped_reg   <= 1'b0;
            emit_cnt_reg  <= 7'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            frame_reg     <= frame_next;
            len_reg       <= len_next;
            bcnt_reg      <= bcnt_next;
            held_reg      <= held_next;
            stopped_reg   <= stopped_next;
            emit_cnt_reg  <= emit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg          <= hi_next;
        byte_reg        <= byte_next;
        eos_reg         <= eos_next;
        emit_frame_reg  <= emit_frame_next;
        emit_sign_reg   <= emit_sign_next;
        emit_total_reg  <= emit_total_next;
        emit_status_reg <= emit_status_next;
        kind_reg        <= kind_next;
        frame_index_reg <= frame_index_next;
        word_index_reg  <= word_index_next;
        word_value_reg  <= word_value_next;
        is_signed_reg   <= is_signed_next;
        status_reg      <= status_next;
        last_reg        <= last_next;
    end

    assign crc_data    = data_byte;
    assign mem_rd_addr = emit_cnt_reg[AW-1:0];

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign frame_index = frame_index_reg;
    assign word_index  = word_index_reg;
    assign word_value  = word_value_reg;
    assign is_signed   = is_signed_reg;
    assign status      = status_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    a_accept_starts_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == SEQ_CRC && crc_stat.busy))
        else $error("accepted item did not start the CRC pass");

    a_stopped_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_DECIDE && stopped_reg) |=> (state_reg == SEQ_IDLE))
        else $error("stopped parser produced a result");

    a_word_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_WORD) |-> (!last_reg && status_reg == ST_OK))
        else $error("word item marked last or carries a status");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        emit_cnt_reg <= 7'(MAX_WORDS))
        else $error("word emission ran past the buffer");
`endif

endmodule

// ===== sv/modbus_rtu_response_deframer.sv =====
// Deframer for back-to-back Modbus RTU read-holding-register replies in one raw sample.
// The input channel (in_valid, in_stall) carries one sample byte per item, with
// end_of_sample set on the last byte. The output channel (out_valid, out_stall)
// carries register words and frame status items; last marks the final result of a byte.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the
// device address, the frame count and the signed frame mask; it is always ready.
// Each accepted byte runs through a bit-serial CRC-16 unit, so a byte that causes no
// result passes the CRC and decide states before the next byte is accepted.
// A status item adds the status state, which loads it into the result register.
// A good frame's N words are each read from the word buffer in a read state and then
// loaded into the result register in a word state, followed by its status item.
// The result register lets the next byte be accepted while the final result of the
// previous byte still waits; while out_stall is high the result holds and, once the
// block needs the result register again, in_stall stays high.
// Reset returns the parser to wait for an address byte and restores the register
// defaults (address 1, three frames, mask 3). The word buffer is not cleared.
module modbus_rtu_response_deframer
    import mrd_pkg::*;
#(
    parameter int MAX_WORDS  = 32,
    parameter int MAX_FRAMES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_sample,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [2:0]  frame_index,
    output logic [4:0]  word_index,
    output logic [15:0] word_value,
    output logic        is_signed,
    output logic [2:0]  status,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

    logic [7:0] device_address_reg, device_address_next;
    logic [3:0] frames_expected_reg, frames_expected_next;
    logic [7:0] signed_frame_mask_reg, signed_frame_mask_next;
    logic [3:0] frames_eff;

    crc_cmd_t      crc_cmd;
    crc_stat_t     crc_stat;
    logic [7:0]    crc_data;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [15:0]   mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [15:0]   mem_rd_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        device_address_next    = device_address_reg;
        frames_expected_next   = frames_expected_reg;
        signed_frame_mask_next = signed_frame_mask_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DEVICE_ADDRESS:    device_address_next    = cfg_data;
                CFG_FRAMES_EXPECTED:   frames_expected_next   = cfg_data[3:0];
                CFG_SIGNED_FRAME_MASK: signed_frame_mask_next = cfg_data;
                default:               device_address_next    = device_address_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg    <= DEVICE_ADDRESS_RESET;
            frames_expected_reg   <= FRAMES_EXPECTED_RESET;
            signed_frame_mask_reg <= SIGNED_FRAME_MASK_RESET;
        end
        else
        begin
            device_address_reg    <= device_address_next;
            frames_expected_reg   <= frames_expected_next;
            signed_frame_mask_reg <= signed_frame_mask_next;
        end
    end

    assign frames_eff = (frames_expected_reg > 4'(MAX_FRAMES)) ? 4'(MAX_FRAMES)
                                                               : frames_expected_reg;

    mrd_crc_serial u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (crc_cmd),
        .data  (crc_data),
        .stat  (crc_stat)
    );

    mrd_word_mem #(
        .DEPTH (MAX_WORDS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    mrd_parser #(
        .MAX_WORDS (MAX_WORDS),
        .AW        (AW)
    ) u_parser (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .data_byte         (data_byte),
        .end_of_sample     (end_of_sample),
        .device_address    (device_address_reg),
        .frames_eff        (frames_eff),
        .signed_frame_mask (signed_frame_mask_reg),
        .crc_cmd           (crc_cmd),
        .crc_data          (crc_data),
        .crc_stat          (crc_stat),
        .mem_wr_en         (mem_wr_en),
        .mem_wr_addr       (mem_wr_addr),
        .mem_wr_data       (mem_wr_data),
        .mem_rd_en         (mem_rd_en),
        .mem_rd_addr       (mem_rd_addr),
        .mem_rd_data       (mem_rd_data),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .kind              (kind),
        .frame_index       (frame_index),
        .word_index        (word_index),
        .word_value        (word_value),
        .is_signed         (is_signed),
        .status            (status),
        .last              (last)
    );

endmodule
